FILE: hw/rtl/lbmc_pkg.sv
`timescale 1ns / 1ps

package lbmc_pkg;

  // Fixed point layout and constants of the collision kernel.
  localparam int MAXW = 64;
  localparam int FRAC = 28;
  localparam int NDIR = 9;
  localparam int POP_W = 32;
  localparam int SPLIT_DIR = 5;
  localparam int OMEGA_W = 30;
  localparam int FLAGS_W = 2;
  localparam int IN_DATA_W = (NDIR + 1) * POP_W;
  localparam int OUT_DATA_W = (NDIR + 3) * POP_W;

  // Bit positions in the input tuser.
  localparam int TUSER_OBST = 0;
  localparam int TUSER_INLET = 1;

  // Divider lanes.
  localparam int NLANES = 3;
  localparam int LANE_UX = 0;
  localparam int LANE_UY = 1;
  localparam int LANE_RHO = 2;

  localparam longint Q_ONE = 268435456;
  localparam longint Q_HALF = 134217728;
  localparam longint Q_THREE_HALF = 402653184;
  localparam longint Q_THREE = 805306368;
  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 30'd536285723;

  // Lattice directions and equilibrium weights (rest, edge, corner).
  localparam int DIR_X [NDIR] = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
  localparam int DIR_Y [NDIR] = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
  localparam int WCLASS [NDIR] = '{2, 1, 2, 1, 0, 1, 2, 1, 2};
  localparam longint WEIGHT_Q [3] = '{119304647, 29826162, 7456540};

  typedef logic signed [MAXW:0] wide_t;
  typedef logic signed [MAXW+1:0] sum_t;

  typedef struct packed {
    logic obstacle;
    logic inlet;
  } node_flags_t;

  // Clip a value to the signed range of w bits.
  function automatic wide_t sat_w(input sum_t v, input int unsigned w);
    sum_t vmax;
    sum_t vmin;
    vmax = sum_t'((sum_t'(1) <<< (w - 1)) - sum_t'(1));
    vmin = -vmax - sum_t'(1);
    if (v > vmax) return wide_t'(vmax);
    if (v < vmin) return wide_t'(vmin);
    return wide_t'(v);
  endfunction

  function automatic wide_t sat_add(input wide_t a, input wide_t b, input int unsigned w);
    return sat_w(sum_t'(a) + sum_t'(b), w);
  endfunction

  function automatic wide_t sat_sub(input wide_t a, input wide_t b, input int unsigned w);
    return sat_w(sum_t'(a) - sum_t'(b), w);
  endfunction

endpackage

FILE: hw/rtl/lbmc_moments.sv
`timescale 1ns / 1ps

module lbmc_moments #(
  parameter int W = 32,
  parameter int IW = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [lbmc_pkg::NDIR-1:0][lbmc_pkg::POP_W-1:0] pop_i,
  input  lbmc_pkg::node_flags_t                      flags_i,
  input  logic [lbmc_pkg::POP_W-1:0]                 uin_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [lbmc_pkg::NDIR-1:0][IW-1:0]          f_o,
  output lbmc_pkg::node_flags_t                      flags_o,
  output logic [IW-1:0]                              uin_o,
  output logic [IW-1:0]                              rho_o,
  output logic [IW-1:0]                              mx_o,
  output logic [IW-1:0]                              my_o,
  output logic [IW-1:0]                              rnum_o,
  output logic [IW-1:0]                              rden_o
);
  import lbmc_pkg::*;

  typedef logic signed [IW-1:0] val_t;

  function automatic val_t add(input val_t a, input val_t b);
    return val_t'(sat_add(wide_t'(a), wide_t'(b), W));
  endfunction

  function automatic val_t sub(input val_t a, input val_t b);
    return val_t'(sat_sub(wide_t'(a), wide_t'(b), W));
  endfunction

  logic v_q [1:3];
  logic ld [1:4];

  val_t        f1_q [NDIR];
  val_t        uin1_q;
  node_flags_t fl1_q;

  val_t        f2_q [NDIR];
  val_t        uin2_q, ra2_q, mxa2_q, mya2_q, s2_q, s3_q;
  node_flags_t fl2_q;

  val_t        f3_q [NDIR];
  val_t        uin3_q, rho3_q, mx3_q, my3_q, rnum3_q, rden3_q;
  node_flags_t fl3_q;

  val_t ra_d, mxa_d, mya_d, rho_d, mx_d, my_d;

  // A stage loads when it is empty or the next one moves on.
  assign ld[4] = out_ready_i;
  for (genvar n = 1; n <= 3; n++) begin : g_ld
    assign ld[n] = !v_q[n] || ld[n+1];
  end
  assign in_ready_o = ld[1];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[1] <= 1'b0;
      v_q[2] <= 1'b0;
      v_q[3] <= 1'b0;
    end else begin
      if (ld[1]) v_q[1] <= in_valid_i;
      if (ld[2]) v_q[2] <= v_q[1];
      if (ld[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage 1: clip the incoming words to the working range.
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int k = 0; k < NDIR; k++) begin
        f1_q[k] <= val_t'(sat_w(sum_t'($signed(pop_i[k])), W));
      end
      uin1_q <= val_t'(sat_w(sum_t'($signed(uin_i)), W));
      fl1_q <= flags_i;
    end
  end

  // Stage 2: first half of the ordered sums, plus the inlet partial sums.
  always_comb begin
    ra_d = '0;
    mxa_d = '0;
    mya_d = '0;
    for (int k = 0; k < SPLIT_DIR; k++) begin
      ra_d = add(ra_d, f1_q[k]);
      if (DIR_X[k] > 0) mxa_d = add(mxa_d, f1_q[k]);
      else if (DIR_X[k] < 0) mxa_d = sub(mxa_d, f1_q[k]);
      if (DIR_Y[k] > 0) mya_d = add(mya_d, f1_q[k]);
      else if (DIR_Y[k] < 0) mya_d = sub(mya_d, f1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      f2_q <= f1_q;
      uin2_q <= uin1_q;
      fl2_q <= fl1_q;
      ra2_q <= ra_d;
      mxa2_q <= mxa_d;
      mya2_q <= mya_d;
      s2_q <= add(add(f1_q[3], f1_q[4]), f1_q[5]);
      s3_q <= add(add(f1_q[6], f1_q[7]), f1_q[8]);
    end
  end

  // Stage 3: finish the sums and build the inlet density quotient operands.
  always_comb begin
    rho_d = ra2_q;
    mx_d = mxa2_q;
    my_d = mya2_q;
    for (int k = SPLIT_DIR; k < NDIR; k++) begin
      rho_d = add(rho_d, f2_q[k]);
      if (DIR_X[k] > 0) mx_d = add(mx_d, f2_q[k]);
      else if (DIR_X[k] < 0) mx_d = sub(mx_d, f2_q[k]);
      if (DIR_Y[k] > 0) my_d = add(my_d, f2_q[k]);
      else if (DIR_Y[k] < 0) my_d = sub(my_d, f2_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      f3_q <= f2_q;
      uin3_q <= uin2_q;
      fl3_q <= fl2_q;
      rho3_q <= rho_d;
      mx3_q <= mx_d;
      my3_q <= my_d;
      rnum3_q <= add(s2_q, add(s3_q, s3_q));
      rden3_q <= sub(val_t'(Q_ONE), uin2_q);
    end
  end

  for (genvar k = 0; k < NDIR; k++) begin : g_fo
    assign f_o[k] = f3_q[k];
  end
  assign flags_o = fl3_q;
  assign uin_o = uin3_q;
  assign rho_o = rho3_q;
  assign mx_o = mx3_q;
  assign my_o = my3_q;
  assign rnum_o = rnum3_q;
  assign rden_o = rden3_q;

endmodule

FILE: hw/rtl/lbmc_div.sv
`timescale 1ns / 1ps

module lbmc_div #(
  parameter int W = 32,
  parameter int IW = 32,
  parameter int LANES = 3,
  parameter int PW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [LANES-1:0][IW-1:0]    num_i,
  input  logic [LANES-1:0][IW-1:0]    den_i,
  input  logic [PW-1:0]               pay_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LANES-1:0][IW-1:0]    quo_o,
  output logic [PW-1:0]               pay_o
);
  import lbmc_pkg::*;

  // One quotient bit per stage, restoring long division on magnitudes.
  localparam int MW = IW;
  localparam int QB = MW + FRAC;
  localparam int NS = QB + 1;
  localparam logic [QB-1:0] LIM_POS = (QB'(1) << (W - 1)) - QB'(1);
  localparam logic [QB-1:0] LIM_NEG = QB'(1) << (W - 1);

  typedef logic signed [IW-1:0] val_t;

  logic                       v_q   [NS];
  logic                       ld    [NS+1];
  logic [LANES-1:0][MW:0]     rem_q [NS];
  logic [LANES-1:0][QB-1:0]   sh_q  [NS];
  logic [LANES-1:0][MW-1:0]   dv_q  [NS];
  logic [LANES-1:0]           neg_q [NS];
  logic [LANES-1:0]           dz_q  [NS];
  logic [LANES-1:0]           nz_q  [NS];
  logic [LANES-1:0]           npos_q[NS];
  logic [PW-1:0]              pay_q [NS];

  assign ld[NS] = out_ready_i;
  for (genvar s = 0; s < NS; s++) begin : g_ld
    assign ld[s] = !v_q[s] || ld[s+1];
  end
  assign in_ready_o = ld[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (ld[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // Entry stage: split into sign and magnitude, note the zero cases.
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= '0;
        sh_q[0][l] <= {(num_i[l][IW-1] ? MW'(-$signed(num_i[l])) : MW'(num_i[l])),
                       FRAC'(0)};
        dv_q[0][l] <= den_i[l][IW-1] ? MW'(-$signed(den_i[l])) : MW'(den_i[l]);
        neg_q[0][l] <= num_i[l][IW-1] ^ den_i[l][IW-1];
        dz_q[0][l] <= (den_i[l] == '0);
        nz_q[0][l] <= (num_i[l] == '0);
        npos_q[0][l] <= !num_i[l][IW-1];
      end
      pay_q[0] <= pay_i;
    end
  end

  // Division steps: shift in one numerator bit, subtract when it fits.
  for (genvar s = 1; s < NS; s++) begin : g_step
    logic [LANES-1:0][MW:0]   rem_d;
    logic [LANES-1:0][QB-1:0] sh_d;

    always_comb begin
      logic [MW:0] trial;
      logic        fits;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_q[s-1][l][MW-1:0], sh_q[s-1][l][QB-1]};
        fits = (trial >= {1'b0, dv_q[s-1][l]});
        rem_d[l] = fits ? trial - {1'b0, dv_q[s-1][l]} : trial;
        sh_d[l] = {sh_q[s-1][l][QB-2:0], fits};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[s]) begin
        rem_q[s] <= rem_d;
        sh_q[s] <= sh_d;
        dv_q[s] <= dv_q[s-1];
        neg_q[s] <= neg_q[s-1];
        dz_q[s] <= dz_q[s-1];
        nz_q[s] <= nz_q[s-1];
        npos_q[s] <= npos_q[s-1];
        pay_q[s] <= pay_q[s-1];
      end
    end
  end

  // Saturate the quotient and restore its sign; a zero divisor gives zero or a saturated value.
  always_comb begin
    logic [QB-1:0] mag;
    logic [QB-1:0] lim;
    for (int l = 0; l < LANES; l++) begin
      lim = neg_q[NS-1][l] ? LIM_NEG : LIM_POS;
      mag = (sh_q[NS-1][l] > lim) ? lim : sh_q[NS-1][l];
      if (dz_q[NS-1][l]) begin
        if (nz_q[NS-1][l]) quo_o[l] = '0;
        else if (npos_q[NS-1][l]) quo_o[l] = IW'(LIM_POS);
        else quo_o[l] = IW'(-LIM_NEG);
      end else begin
        quo_o[l] = neg_q[NS-1][l] ? IW'(-mag) : IW'(mag);
      end
    end
  end
  assign pay_o = pay_q[NS-1];

endmodule

FILE: hw/rtl/lbmc_equil.sv
`timescale 1ns / 1ps

module lbmc_equil #(
  parameter int W = 32,
  parameter int IW = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [lbmc_pkg::NLANES-1:0][IW-1:0]    quo_i,
  input  logic [lbmc_pkg::NDIR-1:0][IW-1:0]      f_i,
  input  lbmc_pkg::node_flags_t                  flags_i,
  input  logic [IW-1:0]                          uin_i,
  input  logic [IW-1:0]                          rho_i,
  input  logic [lbmc_pkg::OMEGA_W-1:0]           omega_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [lbmc_pkg::NDIR-1:0][IW-1:0]      res_o,
  output logic [IW-1:0]                          rho_o,
  output logic [IW-1:0]                          ux_o,
  output logic [IW-1:0]                          uy_o
);
  import lbmc_pkg::*;

  localparam int MW = IW;
  localparam int PRW = 2 * MW;
  localparam int MSW = PRW - FRAC;
  localparam logic [MSW-1:0] MLIM_POS = (MSW'(1) << (W - 1)) - MSW'(1);
  localparam logic [MSW-1:0] MLIM_NEG = MSW'(1) << (W - 1);

  typedef logic signed [IW-1:0] val_t;

  function automatic val_t add(input val_t a, input val_t b);
    return val_t'(sat_add(wide_t'(a), wide_t'(b), W));
  endfunction

  function automatic val_t sub(input val_t a, input val_t b);
    return val_t'(sat_sub(wide_t'(a), wide_t'(b), W));
  endfunction

  // Fixed point product, magnitude truncated, then saturated.
  function automatic val_t mul(input val_t a, input val_t b);
    logic [MW-1:0]  x;
    logic [MW-1:0]  y;
    logic [PRW-1:0] pr;
    logic [MSW-1:0] m;
    logic [MSW-1:0] lim;
    logic           neg;
    x = a[IW-1] ? MW'(-a) : MW'(a);
    y = b[IW-1] ? MW'(-b) : MW'(b);
    pr = PRW'(x) * PRW'(y);
    m = pr[PRW-1:FRAC];
    neg = a[IW-1] ^ b[IW-1];
    lim = neg ? MLIM_NEG : MLIM_POS;
    if (m > lim) m = lim;
    return neg ? val_t'(-m) : val_t'(m);
  endfunction

  logic v_q [1:8];
  logic ld [1:9];

  assign ld[9] = out_ready_i;
  for (genvar n = 1; n <= 8; n++) begin : g_ld
    assign ld[n] = !v_q[n] || ld[n+1];
  end
  assign in_ready_o = ld[1];
  assign out_valid_o = v_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 1; n <= 8; n++) v_q[n] <= 1'b0;
    end else begin
      if (ld[1]) v_q[1] <= in_valid_i;
      for (int n = 2; n <= 8; n++) begin
        if (ld[n]) v_q[n] <= v_q[n-1];
      end
    end
  end

  val_t        f1_q [NDIR], s1_q [NDIR], rw1_q [3];
  val_t        rho1_q, ux1_q, uy1_q, sqx1_q, sqy1_q;
  node_flags_t fl1_q;
  val_t        f2_q [NDIR], cu2_q [NDIR], rw2_q [3];
  val_t        rho2_q, ux2_q, uy2_q, usum2_q;
  node_flags_t fl2_q;
  val_t        f3_q [NDIR], cc3_q [NDIR], t13_q [NDIR], rw3_q [3];
  val_t        rho3_q, ux3_q, uy3_q, usqr3_q;
  node_flags_t fl3_q;
  val_t        f4_q [NDIR], t4_q [NDIR], rw4_q [3];
  val_t        rho4_q, ux4_q, uy4_q;
  node_flags_t fl4_q;
  val_t        f5_q [NDIR], feq5_q [NDIR];
  val_t        rho5_q, ux5_q, uy5_q;
  node_flags_t fl5_q;
  val_t        g6_q [NDIR], d6_q [NDIR];
  val_t        rho6_q, ux6_q, uy6_q;
  node_flags_t fl6_q;
  val_t        g7_q [NDIR], p7_q [NDIR];
  val_t        rho7_q, ux7_q, uy7_q;
  node_flags_t fl7_q;
  val_t        res8_q [NDIR];
  val_t        rho8_q, ux8_q, uy8_q;

  val_t ux_s, uy_s, rho_s;
  val_t sk_s [NDIR];
  val_t g_s [NDIR];

  // Stage 1: pick the inlet or computed moments, square, project, weight.
  always_comb begin
    ux_s = flags_i.inlet ? val_t'(uin_i) : val_t'(quo_i[LANE_UX]);
    uy_s = flags_i.inlet ? val_t'(0) : val_t'(quo_i[LANE_UY]);
    rho_s = flags_i.inlet ? val_t'(quo_i[LANE_RHO]) : val_t'(rho_i);
    for (int k = 0; k < NDIR; k++) begin
      sk_s[k] = '0;
      if (DIR_X[k] > 0) sk_s[k] = add(sk_s[k], ux_s);
      else if (DIR_X[k] < 0) sk_s[k] = sub(sk_s[k], ux_s);
      if (DIR_Y[k] > 0) sk_s[k] = add(sk_s[k], uy_s);
      else if (DIR_Y[k] < 0) sk_s[k] = sub(sk_s[k], uy_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int k = 0; k < NDIR; k++) begin
        f1_q[k] <= val_t'(f_i[k]);
        s1_q[k] <= sk_s[k];
      end
      for (int c = 0; c < 3; c++) rw1_q[c] <= mul(rho_s, val_t'(WEIGHT_Q[c]));
      fl1_q <= flags_i;
      rho1_q <= rho_s;
      ux1_q <= ux_s;
      uy1_q <= uy_s;
      sqx1_q <= mul(ux_s, ux_s);
      sqy1_q <= mul(uy_s, uy_s);
    end
  end

  // Stage 2: velocity square sum and scaled projections.
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      f2_q <= f1_q;
      rw2_q <= rw1_q;
      fl2_q <= fl1_q;
      rho2_q <= rho1_q;
      ux2_q <= ux1_q;
      uy2_q <= uy1_q;
      usum2_q <= add(sqx1_q, sqy1_q);
      for (int k = 0; k < NDIR; k++) cu2_q[k] <= mul(val_t'(Q_THREE), s1_q[k]);
    end
  end

  // Stage 3: usqr, cu squared and the linear term.
  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      f3_q <= f2_q;
      rw3_q <= rw2_q;
      fl3_q <= fl2_q;
      rho3_q <= rho2_q;
      ux3_q <= ux2_q;
      uy3_q <= uy2_q;
      usqr3_q <= mul(val_t'(Q_THREE_HALF), usum2_q);
      for (int k = 0; k < NDIR; k++) begin
        cc3_q[k] <= mul(cu2_q[k], cu2_q[k]);
        t13_q[k] <= add(val_t'(Q_ONE), cu2_q[k]);
      end
    end
  end

  // Stage 4: the polynomial of the equilibrium.
  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      f4_q <= f3_q;
      rw4_q <= rw3_q;
      fl4_q <= fl3_q;
      rho4_q <= rho3_q;
      ux4_q <= ux3_q;
      uy4_q <= uy3_q;
      for (int k = 0; k < NDIR; k++) begin
        t4_q[k] <= sub(add(t13_q[k], mul(val_t'(Q_HALF), cc3_q[k])), usqr3_q);
      end
    end
  end

  // Stage 5: equilibrium populations.
  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      f5_q <= f4_q;
      fl5_q <= fl4_q;
      rho5_q <= rho4_q;
      ux5_q <= ux4_q;
      uy5_q <= uy4_q;
      for (int k = 0; k < NDIR; k++) feq5_q[k] <= mul(rw4_q[WCLASS[k]], t4_q[k]);
    end
  end

  // Stage 6: replace the east-going populations at an inlet, then the deviation.
  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      if (fl5_q.inlet && (DIR_X[k] > 0)) begin
        g_s[k] = sub(add(feq5_q[k], f5_q[NDIR-1-k]), feq5_q[NDIR-1-k]);
      end else begin
        g_s[k] = f5_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      fl6_q <= fl5_q;
      rho6_q <= rho5_q;
      ux6_q <= ux5_q;
      uy6_q <= uy5_q;
      for (int k = 0; k < NDIR; k++) begin
        g6_q[k] <= g_s[k];
        d6_q[k] <= sub(g_s[k], feq5_q[k]);
      end
    end
  end

  // Stage 7: scale the deviation by omega.
  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      g7_q <= g6_q;
      fl7_q <= fl6_q;
      rho7_q <= rho6_q;
      ux7_q <= ux6_q;
      uy7_q <= uy6_q;
      for (int k = 0; k < NDIR; k++) p7_q[k] <= mul(val_t'(omega_i), d6_q[k]);
    end
  end

  // Stage 8: relax a fluid node, or bounce back an obstacle node.
  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      rho8_q <= rho7_q;
      ux8_q <= ux7_q;
      uy8_q <= uy7_q;
      for (int k = 0; k < NDIR; k++) begin
        res8_q[k] <= fl7_q.obstacle ? g7_q[NDIR-1-k] : sub(g7_q[k], p7_q[k]);
      end
    end
  end

  for (genvar k = 0; k < NDIR; k++) begin : g_res
    assign res_o[k] = res8_q[k];
  end
  assign rho_o = rho8_q;
  assign ux_o = ux8_q;
  assign uy_o = uy8_q;

endmodule

FILE: hw/rtl/lbm_d2q9_node_collision.sv
`timescale 1ns / 1ps
// Widths below 32 bits run on a 32-bit datapath.
// Throughput: one node per cycle while the output is not stalled; the divider resolves one
// quotient bit per pipeline stage for all three quotients of a node at once.
// Reset: asynchronous, active low; clears every stage valid bit and loads omega with
// its reset value. There is no clearing pass.
module lbm_d2q9_node_collision #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input: pop_in_0 .. pop_in_8, inlet_velocity
  input  logic [lbmc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // Input: is_obstacle, is_inlet
  input  logic [lbmc_pkg::FLAGS_W-1:0]         s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Output: pop_out_0 .. pop_out_8, density, velocity_x, velocity_y
  output logic [lbmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lbmc_pkg::OMEGA_W-1:0]         cfg_data_i
);
  import lbmc_pkg::*;

  localparam int IW = (VALUE_WIDTH > POP_W) ? VALUE_WIDTH : POP_W;
  localparam int PW = (NDIR + 2) * IW + FLAGS_W;

  logic [OMEGA_W-1:0] omega_q;

  logic [NDIR-1:0][POP_W-1:0] pop_in;
  node_flags_t                in_flags;

  logic                       mo_valid, mo_ready;
  logic [NDIR-1:0][IW-1:0]    mo_f;
  node_flags_t                mo_flags;
  logic [IW-1:0]              mo_uin, mo_rho, mo_mx, mo_my, mo_rnum, mo_rden;

  logic                       dv_valid, dv_ready;
  logic [NLANES-1:0][IW-1:0]  dv_quo;
  logic [PW-1:0]              dv_pay;

  logic [NDIR-1:0][IW-1:0]    eq_res;
  logic [IW-1:0]              eq_rho, eq_ux, eq_uy;

  // The relaxation factor register; writes always complete at once.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= OMEGA_RESET;
    end else if (cfg_valid_i) begin
      omega_q <= cfg_data_i;
    end
  end

  // Unpack the input transaction.
  for (genvar k = 0; k < NDIR; k++) begin : g_in
    assign pop_in[k] = s_axis_tdata[k*POP_W +: POP_W];
  end
  assign in_flags.obstacle = s_axis_tuser[TUSER_OBST];
  assign in_flags.inlet = s_axis_tuser[TUSER_INLET];

  lbmc_moments #(
    .W  (VALUE_WIDTH),
    .IW (IW)
  ) u_moments (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pop_i       (pop_in),
    .flags_i     (in_flags),
    .uin_i       (s_axis_tdata[NDIR*POP_W +: POP_W]),
    .out_valid_o (mo_valid),
    .out_ready_i (mo_ready),
    .f_o         (mo_f),
    .flags_o     (mo_flags),
    .uin_o       (mo_uin),
    .rho_o       (mo_rho),
    .mx_o        (mo_mx),
    .my_o        (mo_my),
    .rnum_o      (mo_rnum),
    .rden_o      (mo_rden)
  );

  // Velocity and inlet density quotients, node data riding alongside.
  lbmc_div #(
    .W     (VALUE_WIDTH),
    .IW    (IW),
    .LANES (NLANES),
    .PW    (PW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mo_valid),
    .in_ready_o  (mo_ready),
    .num_i       ({mo_rnum, mo_my, mo_mx}),
    .den_i       ({mo_rden, mo_rho, mo_rho}),
    .pay_i       ({mo_flags, mo_rho, mo_uin, mo_f}),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .quo_o       (dv_quo),
    .pay_o       (dv_pay)
  );

  lbmc_equil #(
    .W  (VALUE_WIDTH),
    .IW (IW)
  ) u_equil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .quo_i       (dv_quo),
    .f_i         (dv_pay[NDIR*IW-1:0]),
    .flags_i     (node_flags_t'(dv_pay[PW-1 -: FLAGS_W])),
    .uin_i       (dv_pay[NDIR*IW +: IW]),
    .rho_i       (dv_pay[(NDIR+1)*IW +: IW]),
    .omega_i     (omega_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (eq_res),
    .rho_o       (eq_rho),
    .ux_o        (eq_ux),
    .uy_o        (eq_uy)
  );

  // Pack the result transaction.
  for (genvar k = 0; k < NDIR; k++) begin : g_out
    assign m_axis_tdata[k*POP_W +: POP_W] = eq_res[k][POP_W-1:0];
  end
  assign m_axis_tdata[NDIR*POP_W +: POP_W] = eq_rho[POP_W-1:0];
  assign m_axis_tdata[(NDIR+1)*POP_W +: POP_W] = eq_ux[POP_W-1:0];
  assign m_axis_tdata[(NDIR+2)*POP_W +: POP_W] = eq_uy[POP_W-1:0];

  // Back pressure at the input only comes from a full pipe behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // A configuration write lands in omega on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (omega_q == $past(cfg_data_i)))
    else $error("omega write lost");

endmodule

FILE: sim/lbm_collision_checker.sv
`timescale 1ns / 1ps

module lbm_collision_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input: pop_in_0 .. pop_in_8, inlet_velocity
  input  logic [lbmc_pkg::IN_DATA_W-1:0]      s_tdata_i,
  // Input: is_obstacle, is_inlet
  input  logic [lbmc_pkg::FLAGS_W-1:0]        s_tuser_i,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  // Output: pop_out_0 .. pop_out_8, density, velocity_x, velocity_y
  input  logic [lbmc_pkg::OUT_DATA_W-1:0]     m_tdata_i,
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [lbmc_pkg::OMEGA_W-1:0]        cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import lbmc_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint W_REST = 119304647;
  localparam longint W_EDGE = 29826162;
  localparam longint W_CORNER = 7456540;
  localparam int DX [NDIR] = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
  localparam int DY [NDIR] = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
  localparam longint WGT [NDIR] = '{W_CORNER, W_EDGE, W_CORNER, W_EDGE, W_REST,
                                    W_EDGE, W_CORNER, W_EDGE, W_CORNER};

  logic [OMEGA_W-1:0] omega_q;
  logic [OUT_DATA_W-1:0] expected_nodes [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o = expected_nodes.size();

  function automatic longint clip(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    return clip(a + b);
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    return clip(a - b);
  endfunction

  // Signed value from a magnitude, saturated to the 32-bit range.
  function automatic longint from_mag(input bit neg, input longint unsigned m);
    if (neg) begin
      if (m > 64'd2147483648) m = 64'd2147483648;
      return -longint'(m);
    end
    if (m > 64'd2147483647) m = 64'd2147483647;
    return longint'(m);
  endfunction

  // Q4.28 product, magnitude truncated.
  function automatic longint q_mul(input longint a, input longint b);
    longint unsigned x;
    longint unsigned y;
    x = (a < 0) ? longint'(-a) : a;
    y = (b < 0) ? longint'(-b) : b;
    return from_mag((a < 0) != (b < 0), (x * y) >> FRAC);
  endfunction

  // Q4.28 quotient; division by zero saturates toward the numerator's sign, and zero by zero gives zero.
  function automatic longint q_div(input longint a, input longint b);
    longint unsigned x;
    longint unsigned y;
    if (b == 0) begin
      if (a == 0) return 0;
      return (a > 0) ? VMAX : VMIN;
    end
    x = (a < 0) ? longint'(-a) : a;
    y = (b < 0) ? longint'(-b) : b;
    return from_mag((a < 0) != (b < 0), (x << FRAC) / y);
  endfunction

  // Full node update: moments, equilibrium, inlet, then bounce-back or BGK.
  function automatic logic [OUT_DATA_W-1:0] collide_node(
    input logic [IN_DATA_W-1:0] din, input logic [FLAGS_W-1:0] flags,
    input logic [OMEGA_W-1:0] omega);
    longint f [NDIR];
    longint feq [NDIR];
    longint res [NDIR];
    longint rho, mx, my, ux, uy, usqr, s2, s3, s, cu, t;
    logic [OUT_DATA_W-1:0] r;
    rho = 0;
    mx = 0;
    my = 0;
    for (int k = 0; k < NDIR; k++) f[k] = longint'($signed(din[32*k +: 32]));
    for (int k = 0; k < NDIR; k++) begin
      rho = q_add(rho, f[k]);
      if (DX[k] > 0) mx = q_add(mx, f[k]);
      if (DX[k] < 0) mx = q_sub(mx, f[k]);
      if (DY[k] > 0) my = q_add(my, f[k]);
      if (DY[k] < 0) my = q_sub(my, f[k]);
    end
    ux = q_div(mx, rho);
    uy = q_div(my, rho);
    if (flags[TUSER_INLET]) begin
      s2 = q_add(q_add(f[3], f[4]), f[5]);
      s3 = q_add(q_add(f[6], f[7]), f[8]);
      ux = longint'($signed(din[32*NDIR +: 32]));
      uy = 0;
      rho = q_div(q_add(s2, q_add(s3, s3)), q_sub(Q_ONE, ux));
    end
    usqr = q_mul(Q_THREE_HALF, q_add(q_mul(ux, ux), q_mul(uy, uy)));
    for (int k = 0; k < NDIR; k++) begin
      s = 0;
      if (DX[k] > 0) s = q_add(s, ux);
      if (DX[k] < 0) s = q_sub(s, ux);
      if (DY[k] > 0) s = q_add(s, uy);
      if (DY[k] < 0) s = q_sub(s, uy);
      cu = q_mul(Q_THREE, s);
      t = q_add(Q_ONE, cu);
      t = q_add(t, q_mul(Q_HALF, q_mul(cu, cu)));
      t = q_sub(t, usqr);
      feq[k] = q_mul(q_mul(rho, WGT[k]), t);
    end
    // The inlet rebuilds the three east-going populations.
    if (flags[TUSER_INLET]) begin
      for (int k = 0; k < 3; k++) f[k] = q_sub(q_add(feq[k], f[8-k]), feq[8-k]);
    end
    for (int k = 0; k < NDIR; k++) begin
      if (flags[TUSER_OBST]) res[k] = f[8-k];
      else res[k] = q_sub(f[k], q_mul(longint'(omega), q_sub(f[k], feq[k])));
    end
    for (int k = 0; k < NDIR; k++) r[32*k +: 32] = res[k][31:0];
    r[32*9 +: 32] = rho[31:0];
    r[32*10 +: 32] = ux[31:0];
    r[32*11 +: 32] = uy[31:0];
    return r;
  endfunction

  // Watch every channel; predict on input transactions, compare on output ones.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_DATA_W-1:0] want;
    string fname;
    if (!rst_ni) begin
      omega_q <= OMEGA_RESET;
      fails = 0;
      expected_nodes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) omega_q <= cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        expected_nodes.push_back(collide_node(s_tdata_i, s_tuser_i, omega_q));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_nodes.size() == 0) begin
          $error("result transaction with no expected result");
          fails++;
        end else begin
          want = expected_nodes.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (want[32*k +: 32] !== m_tdata_i[32*k +: 32]) begin
              if (k < 9) fname = $sformatf("pop_out_%0d", k);
              else if (k == 9) fname = "density";
              else if (k == 10) fname = "velocity_x";
              else fname = "velocity_y";
              $error("%s: expected %0d, actual %0d", fname,
                     $signed(want[32*k +: 32]), $signed(m_tdata_i[32*k +: 32]));
              fails++;
            end
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_lbm_d2q9_node_collision.sv
`timescale 1ns / 1ps

module tb_lbm_d2q9_node_collision;
  import lbmc_pkg::*;

  localparam int LATENCY = 72;
  localparam logic [31:0] QMAX = 32'h7fffffff;
  localparam logic [31:0] QMIN = 32'h80000000;
  localparam logic [31:0] QONE = 32'h10000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [FLAGS_W-1:0] s_axis_tuser = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [OMEGA_W-1:0] cfg_data_i = '0;
  int fail_count;
  int pending;
  bit hold_output = 1'b0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lbm_d2q9_node_collision dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  lbm_collision_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (hold_output) begin
        stall = 400;
        hold_output = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Offer one node and hold it until the transaction; the gap comes first.
  task automatic send_node(input logic [IN_DATA_W-1:0] data, input logic [FLAGS_W-1:0] flags);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= data;
    s_axis_tuser <= flags;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drain the block completely before touching the register.
  task automatic drain_pipeline;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_omega(input logic [OMEGA_W-1:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_pop(input int mode);
    case (mode)
      0: return 32'($urandom_range(0, 32'h0800_0000));
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: return QMAX;
          1: return QMIN;
          2: return '0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Mostly physical nodes with populations between 0 and 0.5, some raw bit patterns and extremes.
  task automatic send_random_node;
    logic [IN_DATA_W-1:0] data;
    logic [FLAGS_W-1:0] flags;
    int mode;
    int sel;
    sel = $urandom_range(0, 99);
    mode = (sel < 70) ? 0 : (sel < 85) ? 1 : 2;
    for (int k = 0; k < NDIR; k++) data[32*k +: 32] = pick_pop(mode);
    if (mode == 0) data[32*NDIR +: 32] = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    else data[32*NDIR +: 32] = pick_pop(mode);
    flags[TUSER_OBST] = ($urandom_range(0, 4) == 0);
    flags[TUSER_INLET] = ($urandom_range(0, 4) == 0);
    send_node(data, flags);
  endtask

  function automatic logic [IN_DATA_W-1:0] fill_node(input logic [31:0] pop,
                                                     input logic [31:0] uin);
    logic [IN_DATA_W-1:0] d;
    for (int k = 0; k < NDIR; k++) d[32*k +: 32] = pop;
    d[32*NDIR +: 32] = uin;
    return d;
  endfunction

  initial begin
    logic [IN_DATA_W-1:0] d;
    logic [OMEGA_W-1:0] settings [6];
    settings = '{30'd0, 30'd536870912, 30'd268435456, 30'd1, 30'd402653184, 30'd536285723};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed nodes at the reset value of omega.
    for (int fl = 0; fl < 4; fl++) begin
      send_node(fill_node('0, '0), FLAGS_W'(fl));
      send_node(fill_node(QMAX, QMAX), FLAGS_W'(fl));
      send_node(fill_node(QMIN, QMIN), FLAGS_W'(fl));
      send_node(fill_node(32'h01c7_1c72, 32'h0199_999a), FLAGS_W'(fl));
    end
    // Inlet velocity of one: the density divisor is zero.
    send_node(fill_node(32'h01c7_1c72, QONE), 2'b10);
    send_node(fill_node(32'h01c7_1c72, QONE), 2'b11);
    // Zero density with momentum: velocity saturates.
    d = fill_node('0, '0);
    d[32*1 +: 32] = QONE;
    d[32*7 +: 32] = -QONE;
    send_node(d, 2'b00);
    d[32*1 +: 32] = -QONE;
    d[32*7 +: 32] = QONE;
    send_node(d, 2'b00);
    d = fill_node('0, 32'hf000_0000);
    d[32*4 +: 32] = QONE;
    send_node(d, 2'b10);
    send_node(d, 2'b01);
    drain_pipeline();

    // Random phases, each at its own omega.
    for (int p = 0; p < 6; p++) begin
      write_omega(p == 3 ? OMEGA_W'($urandom_range(0, 536870912)) : settings[p]);
      no_gaps = (p == 2);
      if (p == 1) hold_output = 1'b1;
      for (int i = 0; i < 165; i++) begin
        if (p == 4 && i == 80) begin
          no_gaps = 1'b1;
          hold_output = 1'b1;
        end
        send_random_node();
      end
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("lbm_d2q9_node_collision test passed");
    end else begin
      $display("lbm_d2q9_node_collision test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("lbm_d2q9_node_collision test failed");
    $finish;
  end

endmodule
